// File: hdl/interlock_request_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Interlock request sequencer assertion macros
// Concurrent assertion helpers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef INTERLOCK_REQUEST_SEQUENCER_MACROS_SVH
`define INTERLOCK_REQUEST_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

`define IRS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define IRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IRS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`define IRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/irs_pkg.sv
// ----------------------------------------------------------------------------
// Interlock request sequencer package
// Codes, item and result types shared by the sequencer modules.
// ----------------------------------------------------------------------------
package irs_pkg;

  localparam logic [7:0] WaitTicksReset = 8'd1;
  localparam logic [7:0] ErrCountMax    = 8'hFF;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    RQ_NONE  = 3'd0,
    RQ_INIT  = 3'd1,
    RQ_OPEN  = 3'd2,
    RQ_CLOSE = 3'd3,
    RQ_ERROR = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    RS_OK      = 2'd0,
    RS_ALREADY = 2'd1,
    RS_ILLEGAL = 2'd2,
    RS_PENDING = 2'd3
  } status_e;

  // Register word index on the configuration port
  typedef enum logic {
    REG_WAIT_TICKS = 1'b0
  } reg_e;

  typedef enum logic [5:0] {
    ST_UNINIT    = 6'b000001,
    ST_INITING   = 6'b000010,
    ST_INITED    = 6'b000100,
    ST_WAITFIRST = 6'b001000,
    ST_OPEN      = 6'b010000,
    ST_CLOSED    = 6'b100000
  } state_e;

  typedef logic [2:0] state_code_t;

  localparam state_code_t CodeUninit    = 3'd0;
  localparam state_code_t CodeIniting   = 3'd1;
  localparam state_code_t CodeInited    = 3'd2;
  localparam state_code_t CodeWaitFirst = 3'd3;
  localparam state_code_t CodeOpen      = 3'd4;
  localparam state_code_t CodeClosed    = 3'd5;

  typedef struct packed {
    logic       opcode;
    logic [2:0] request_code;
    logic       feedback_level;
  } item_t;

  typedef struct packed {
    logic [7:0]  error_count;
    logic        feedback_fault;
    logic        feedback_checked;
    logic        interlock_drive;
    state_code_t machine_state;
    logic [1:0]  request_status;
  } result_t;

  function automatic state_code_t state_code(state_e st);
    state_code_t code;
    code = CodeUninit;
    unique case (st)
      ST_UNINIT:    code = CodeUninit;
      ST_INITING:   code = CodeIniting;
      ST_INITED:    code = CodeInited;
      ST_WAITFIRST: code = CodeWaitFirst;
      ST_OPEN:      code = CodeOpen;
      ST_CLOSED:    code = CodeClosed;
      default:      code = CodeUninit;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/irs_cfg.sv
// ----------------------------------------------------------------------------
// Interlock request sequencer configuration registers
// APB-style register file holding the wait timer reload value.
// ----------------------------------------------------------------------------
module irs_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  wait_ticks_o
);

  logic [7:0] wait_ticks_q;
  logic       sel_wait;
  logic       wr_en;

  assign pready   = 1'b1;
  // word index is paddr[2]; byte lanes ignored
  assign sel_wait = (paddr[2] == irs_pkg::REG_WAIT_TICKS);
  assign wr_en    = psel && penable && pwrite && pready && sel_wait;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_ticks_q <= irs_pkg::WaitTicksReset;
    end else if (wr_en) begin
      wait_ticks_q <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (sel_wait) begin
      prdata = {24'd0, wait_ticks_q};
    end
  end

  assign wait_ticks_o = wait_ticks_q;

endmodule

// File: hdl/irs_step.sv
// ----------------------------------------------------------------------------
// Interlock request sequencer step logic
// Sequencer state and the single-pass update for one request or tick item.
// ----------------------------------------------------------------------------
`include "interlock_request_sequencer_macros.svh"

module irs_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  irs_pkg::item_t    item_i,
  input  logic [7:0]        wait_ticks_i,
  output irs_pkg::result_t  result_o
);

  irs_pkg::state_e  state_q, state_d;
  irs_pkg::req_e    pending_q, pending_d;
  logic [7:0]       timer_q, timer_d;
  logic             drive_q, drive_d;
  logic [7:0]       cnt_q, cnt_d;

  irs_pkg::status_e status;
  logic             checked;
  logic             fault;
  logic             run_step;
  logic             is_tick;

  assign is_tick = (item_i.opcode == irs_pkg::OP_TICK);

  always_comb begin
    state_d  = state_q;
    pending_d = pending_q;
    timer_d  = timer_q;
    drive_d  = drive_q;
    cnt_d    = cnt_q;
    status   = irs_pkg::RS_OK;
    checked  = 1'b0;
    fault    = 1'b0;
    run_step = 1'b0;

    if (!is_tick) begin
      if (item_i.request_code == irs_pkg::RQ_ERROR) begin
        status = irs_pkg::RS_OK;
      end else if (pending_q != irs_pkg::RQ_NONE) begin
        status = irs_pkg::RS_PENDING;
      end else begin
        case (item_i.request_code) inside
          irs_pkg::RQ_INIT: begin
            status = (state_q == irs_pkg::ST_UNINIT) ? irs_pkg::RS_OK
                                                     : irs_pkg::RS_ALREADY;
          end
          irs_pkg::RQ_OPEN, irs_pkg::RQ_CLOSE: status = irs_pkg::RS_OK;
          default: status = irs_pkg::RS_ILLEGAL;
        endcase
      end
      if (status == irs_pkg::RS_OK) begin
        pending_d = irs_pkg::req_e'(item_i.request_code);
      end
    end else begin
      checked = (state_q != irs_pkg::ST_UNINIT);
      fault   = checked && (item_i.feedback_level != drive_q);
      // step when the timer is idle or hits zero on this tick
      if (timer_q != 8'd0) begin
        timer_d = timer_q - 8'd1;
      end
      run_step = (timer_q == 8'd0) || (timer_q == 8'd1);

      if (run_step) begin
        unique case (state_q)
          irs_pkg::ST_UNINIT: begin
            pending_d = irs_pkg::RQ_NONE;
            if (pending_q == irs_pkg::RQ_INIT) begin
              timer_d = wait_ticks_i;
              state_d = irs_pkg::ST_INITING;
            end else if (pending_q != irs_pkg::RQ_NONE) begin
              if (cnt_q != irs_pkg::ErrCountMax) begin
                cnt_d = cnt_q + 8'd1;
              end
            end
          end
          irs_pkg::ST_INITING: begin
            drive_d = 1'b0;
            timer_d = wait_ticks_i;
            state_d = irs_pkg::ST_INITED;
          end
          irs_pkg::ST_INITED: begin
            timer_d = wait_ticks_i;
            state_d = irs_pkg::ST_WAITFIRST;
          end
          irs_pkg::ST_WAITFIRST: begin
            pending_d = irs_pkg::RQ_NONE;
            timer_d   = wait_ticks_i;
            if (pending_q == irs_pkg::RQ_OPEN) begin
              state_d = irs_pkg::ST_OPEN;
            end else if (pending_q == irs_pkg::RQ_CLOSE) begin
              state_d = irs_pkg::ST_CLOSED;
            end
          end
          irs_pkg::ST_OPEN: begin
            drive_d   = 1'b0;
            timer_d   = wait_ticks_i;
            pending_d = irs_pkg::RQ_NONE;
            if (pending_q == irs_pkg::RQ_CLOSE) begin
              state_d = irs_pkg::ST_CLOSED;
            end
          end
          irs_pkg::ST_CLOSED: begin
            drive_d   = 1'b1;
            timer_d   = wait_ticks_i;
            pending_d = irs_pkg::RQ_NONE;
            if (pending_q == irs_pkg::RQ_OPEN) begin
              state_d = irs_pkg::ST_OPEN;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= irs_pkg::ST_UNINIT;
      pending_q <= irs_pkg::RQ_NONE;
      timer_q   <= 8'd0;
      drive_q   <= 1'b0;
      cnt_q     <= 8'd0;
    end else if (fire_i) begin
      state_q   <= state_d;
      pending_q <= pending_d;
      timer_q   <= timer_d;
      drive_q   <= drive_d;
      cnt_q     <= cnt_d;
    end
  end

  always_comb begin
    result_o.request_status   = status;
    result_o.machine_state    = irs_pkg::state_code(state_d);
    result_o.interlock_drive  = drive_d;
    result_o.feedback_checked = checked;
    result_o.feedback_fault   = fault;
    result_o.error_count      = cnt_d;
  end

  `IRS_ASSERT_NEXT(a_timer_held_on_request, clk_i, rst_ni, fire_i && !is_tick, timer_q == $past(timer_q), "timer moved on a request item")
  `IRS_ASSERT_IMPLIES(a_drive_only_on_tick, clk_i, rst_ni, drive_d != drive_q, is_tick, "drive changed outside a tick")
  `IRS_ASSERT_IMPLIES(a_count_monotonic, clk_i, rst_ni, fire_i, cnt_d >= cnt_q, "error count decreased")

endmodule

// File: hdl/interlock_request_sequencer.sv
// ----------------------------------------------------------------------------
// Interlock request sequencer
// Safety interlock request checking and state sequencing on tick items.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while the result path is not stalled, and
// every item gives one result. An accepted item lands in an input register;
// when the result register is free or being taken, the step logic updates the
// sequencer state and writes the result register, which drives m_axis_tvalid.
// A stalled result register holds the item in the input register, which can
// still take one more item while it is empty. Write wait_ticks only while no
// item is in flight.
module interlock_request_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] request_code, [3] feedback_level
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] request_status, [4:2] machine_state, [5] interlock_drive,
  // [6] feedback_checked, [7] feedback_fault, [15:8] error_count
  output logic [15:0] m_axis_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             in_valid_q, in_valid_d;
  irs_pkg::item_t   in_item_q;
  logic             out_valid_q, out_valid_d;
  irs_pkg::result_t out_res_q;
  irs_pkg::result_t step_res;
  logic [7:0]       wait_ticks;
  logic             s_fire;
  logic             advance;

  irs_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .wait_ticks_o (wait_ticks)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = s_fire || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.opcode         <= s_axis_tuser[0];
      in_item_q.request_code   <= s_axis_tdata[2:0];
      in_item_q.feedback_level <= s_axis_tdata[3];
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  irs_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .item_i       (in_item_q),
    .wait_ticks_i (wait_ticks),
    .result_o     (step_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;

endmodule

// File: tb/sv/interlock_request_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interlock request sequencer testbench
// Drives request and tick items with bursty traffic and a stalling receiver,
// predicts every result from an internal copy of the sequencer state and
// checks each result field by field. Covers request refusals, counting of
// refused requests while uninitialized, the full start-up sequence and several
// wait_ticks settings written over the configuration port.
// ----------------------------------------------------------------------------
module interlock_request_sequencer_test;

  localparam int         SatRow    = 10;
  localparam int         SatPairs  = 40;
  localparam int         RandItems = 68;
  // refused requests counted before the row after the burst
  localparam logic [7:0] SatCount  = 8'(SatPairs + 2);

  typedef struct packed {
    irs_pkg::op_e     op;
    logic [2:0]       code;
    logic             fb;
    logic             typed;
    irs_pkg::result_t want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [2:0] request_code, [3] feedback_level
  logic [0:0]  s_axis_tuser;   // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [1:0] request_status, [4:2] machine_state, [5] interlock_drive,
  // [6] feedback_checked, [7] feedback_fault, [15:8] error_count
  logic [15:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Sequencer state as the testbench tracks it
  irs_pkg::state_code_t seq_state;
  logic [2:0]           held_request;
  logic [7:0]           step_timer;
  logic                 drive_now;
  logic [7:0]           refused_count;
  logic [7:0]           wait_reload;

  irs_pkg::result_t results_due[$];
  row_t             rows[$];
  int               fail_count;
  int               burst_left;

  interlock_request_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic irs_pkg::result_t outcome(irs_pkg::status_e s,
                                               irs_pkg::state_code_t st, logic [7:0] cnt);
    irs_pkg::result_t r;
    r.request_status   = s;
    r.machine_state    = st;
    r.interlock_drive  = 1'b0;
    r.feedback_checked = 1'b0;
    r.feedback_fault   = 1'b0;
    r.error_count      = cnt;
    return r;
  endfunction

  function automatic void advance_sequence();
    logic [2:0] taken;
    taken = held_request;
    case (seq_state)
      irs_pkg::CodeUninit: begin
        held_request = irs_pkg::RQ_NONE;
        if (taken == irs_pkg::RQ_INIT) begin
          step_timer = wait_reload;
          seq_state  = irs_pkg::CodeIniting;
        end else if (taken != irs_pkg::RQ_NONE && refused_count != irs_pkg::ErrCountMax) begin
          refused_count = refused_count + 8'd1;
        end
      end
      irs_pkg::CodeIniting: begin
        drive_now  = 1'b0;
        step_timer = wait_reload;
        seq_state  = irs_pkg::CodeInited;
      end
      irs_pkg::CodeInited: begin
        step_timer = wait_reload;
        seq_state  = irs_pkg::CodeWaitFirst;
      end
      irs_pkg::CodeWaitFirst: begin
        held_request = irs_pkg::RQ_NONE;
        step_timer   = wait_reload;
        if (taken == irs_pkg::RQ_OPEN) seq_state = irs_pkg::CodeOpen;
        else if (taken == irs_pkg::RQ_CLOSE) seq_state = irs_pkg::CodeClosed;
      end
      irs_pkg::CodeOpen: begin
        drive_now    = 1'b0;
        step_timer   = wait_reload;
        held_request = irs_pkg::RQ_NONE;
        if (taken == irs_pkg::RQ_CLOSE) seq_state = irs_pkg::CodeClosed;
      end
      irs_pkg::CodeClosed: begin
        drive_now    = 1'b1;
        step_timer   = wait_reload;
        held_request = irs_pkg::RQ_NONE;
        if (taken == irs_pkg::RQ_OPEN) seq_state = irs_pkg::CodeOpen;
      end
      default: ;
    endcase
  endfunction

  function automatic irs_pkg::result_t sequence_item(irs_pkg::item_t it);
    irs_pkg::result_t r;
    irs_pkg::status_e s;
    r = '0;
    s = irs_pkg::RS_OK;
    if (it.opcode == irs_pkg::OP_REQUEST) begin
      if (it.request_code == irs_pkg::RQ_ERROR) s = irs_pkg::RS_OK;
      else if (held_request != irs_pkg::RQ_NONE) s = irs_pkg::RS_PENDING;
      else if (it.request_code == irs_pkg::RQ_INIT) begin
        if (seq_state == irs_pkg::CodeUninit) s = irs_pkg::RS_OK;
        else s = irs_pkg::RS_ALREADY;
      end else if (it.request_code == irs_pkg::RQ_OPEN ||
                   it.request_code == irs_pkg::RQ_CLOSE) s = irs_pkg::RS_OK;
      else s = irs_pkg::RS_ILLEGAL;
      if (s == irs_pkg::RS_OK) held_request = it.request_code;
    end else begin
      if (seq_state != irs_pkg::CodeUninit) begin
        r.feedback_checked = 1'b1;
        r.feedback_fault   = it.feedback_level != drive_now;
      end
      if (step_timer != 8'd0) begin
        step_timer = step_timer - 8'd1;
        if (step_timer == 8'd0) advance_sequence();
      end else begin
        advance_sequence();
      end
    end
    r.request_status  = s;
    r.machine_state   = seq_state;
    r.interlock_drive = drive_now;
    r.error_count     = refused_count;
    return r;
  endfunction

  function automatic irs_pkg::item_t random_item();
    irs_pkg::item_t it;
    int             q;
    it.opcode         = ($urandom_range(0, 99) < 55) ? irs_pkg::OP_TICK : irs_pkg::OP_REQUEST;
    it.feedback_level = 1'($urandom_range(0, 1));
    q = $urandom_range(0, 19);
    if (q < 6) it.request_code = irs_pkg::RQ_OPEN;
    else if (q < 12) it.request_code = irs_pkg::RQ_CLOSE;
    else if (q < 14) it.request_code = irs_pkg::RQ_ERROR;
    else if (q < 16) it.request_code = irs_pkg::RQ_INIT;
    else if (q < 17) it.request_code = irs_pkg::RQ_NONE;
    else it.request_code = 3'($urandom_range(5, 7));
    return it;
  endfunction

  task automatic send_item(irs_pkg::item_t it, logic typed, irs_pkg::result_t want);
    irs_pkg::result_t predicted;
    int               idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (idle) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, it.feedback_level, it.request_code};
    s_axis_tuser  <= it.opcode;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = sequence_item(it);
    results_due.push_back(typed ? want : predicted);
  endtask

  // Hold off until every result is back and the pipeline has emptied
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(irs_pkg::reg_e idx, logic [7:0] value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    wait_reload = value;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== {24'h0, value}) begin
      fail_count++;
      if (fail_count <= 10)
        $display("wait_ticks readback: expected %h, got %h", value, readback);
    end
  endtask

  task automatic check_result(irs_pkg::result_t got);
    irs_pkg::result_t want;
    if (results_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("result %h arrived with nothing outstanding", got);
    end else begin
      want = results_due.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: expected st=%0d state=%0d drv=%b chk=%b flt=%b cnt=%0d",
                   want.request_status, want.machine_state, want.interlock_drive,
                   want.feedback_checked, want.feedback_fault, want.error_count);
          $display("          got      st=%0d state=%0d drv=%b chk=%b flt=%b cnt=%0d",
                   got.request_status, got.machine_state, got.interlock_drive,
                   got.feedback_checked, got.feedback_fault, got.error_count);
        end
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

  // Receiver: stretches of always ready, random stalls and sparse acceptance
  initial begin
    int stretch;
    int style;
    stretch = 0;
    style   = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stretch == 0) begin
        stretch = $urandom_range(8, 64);
        style   = $urandom_range(0, 2);
      end
      stretch--;
      case (style)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= (stretch % 4 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      check_result(irs_pkg::result_t'(m_axis_tdata));
  end

  initial begin
    irs_pkg::item_t it;
    int             phase;
    logic [7:0]     setting;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_count    = 0;
    burst_left    = 0;
    seq_state     = irs_pkg::CodeUninit;
    held_request  = irs_pkg::RQ_NONE;
    step_timer    = 8'd0;
    drive_now     = 1'b0;
    refused_count = 8'd0;
    wait_reload   = irs_pkg::WaitTicksReset;

    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b0, 1'b1,
                    outcome(irs_pkg::RS_OK, irs_pkg::CodeUninit, 8'd0)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_NONE, 1'b0, 1'b1,
                    outcome(irs_pkg::RS_ILLEGAL, irs_pkg::CodeUninit, 8'd0)});
    rows.push_back({irs_pkg::OP_REQUEST, 3'd7, 1'b1, 1'b1,
                    outcome(irs_pkg::RS_ILLEGAL, irs_pkg::CodeUninit, 8'd0)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_OPEN, 1'b0, 1'b1,
                    outcome(irs_pkg::RS_OK, irs_pkg::CodeUninit, 8'd0)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_CLOSE, 1'b1, 1'b1,
                    outcome(irs_pkg::RS_PENDING, irs_pkg::CodeUninit, 8'd0)});
    rows.push_back({irs_pkg::OP_REQUEST, 3'd6, 1'b0, 1'b1,
                    outcome(irs_pkg::RS_PENDING, irs_pkg::CodeUninit, 8'd0)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_ERROR, 1'b0, 1'b1,
                    outcome(irs_pkg::RS_OK, irs_pkg::CodeUninit, 8'd0)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b1, 1'b1,
                    outcome(irs_pkg::RS_OK, irs_pkg::CodeUninit, 8'd1)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_CLOSE, 1'b0, 1'b0,
                    irs_pkg::result_t'('0)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b0, 1'b0, irs_pkg::result_t'('0)});
    // the refused-request burst runs before this row and runs the counter up
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_ERROR, 1'b1, 1'b1,
                    outcome(irs_pkg::RS_OK, irs_pkg::CodeUninit, SatCount)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b1, 1'b1,
                    outcome(irs_pkg::RS_OK, irs_pkg::CodeUninit, SatCount + 8'd1)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_INIT, 1'b0, 1'b1,
                    outcome(irs_pkg::RS_OK, irs_pkg::CodeUninit, SatCount + 8'd1)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_INIT, 1'b0, 1'b1,
                    outcome(irs_pkg::RS_PENDING, irs_pkg::CodeUninit, SatCount + 8'd1)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b1, 1'b1,
                    outcome(irs_pkg::RS_OK, irs_pkg::CodeIniting, SatCount + 8'd1)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_INIT, 1'b1, 1'b1,
                    outcome(irs_pkg::RS_ALREADY, irs_pkg::CodeIniting, SatCount + 8'd1)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b1, 1'b0, irs_pkg::result_t'('0)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b0, 1'b0, irs_pkg::result_t'('0)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_ERROR, 1'b0, 1'b0,
                    irs_pkg::result_t'('0)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b0, 1'b0, irs_pkg::result_t'('0)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_CLOSE, 1'b0, 1'b0,
                    irs_pkg::result_t'('0)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b0, 1'b0, irs_pkg::result_t'('0)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b0, 1'b0, irs_pkg::result_t'('0)});
    rows.push_back({irs_pkg::OP_REQUEST, irs_pkg::RQ_OPEN, 1'b1, 1'b0,
                    irs_pkg::result_t'('0)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b0, 1'b0, irs_pkg::result_t'('0)});
    rows.push_back({irs_pkg::OP_TICK, irs_pkg::RQ_NONE, 1'b1, 1'b0, irs_pkg::result_t'('0)});

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (i == SatRow) begin
        // refuse requests while uninitialized to run the counter up
        repeat (SatPairs) begin
          it.opcode         = irs_pkg::OP_REQUEST;
          it.request_code   = ($urandom_range(0, 2) == 0) ? irs_pkg::RQ_ERROR :
                              ($urandom_range(0, 1) ? irs_pkg::RQ_OPEN : irs_pkg::RQ_CLOSE);
          it.feedback_level = 1'($urandom_range(0, 1));
          send_item(it, 1'b0, '0);
          it.opcode         = irs_pkg::OP_TICK;
          it.feedback_level = 1'($urandom_range(0, 1));
          send_item(it, 1'b0, '0);
        end
      end
      it.opcode         = rows[i].op;
      it.request_code   = rows[i].code;
      it.feedback_level = rows[i].fb;
      send_item(it, rows[i].typed, rows[i].want);
    end

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       setting = 8'd0;
        1:       setting = 8'd255;
        2:       setting = 8'd2;
        3:       setting = 8'($urandom_range(0, 15));
        default: setting = irs_pkg::WaitTicksReset;
      endcase
      settle();
      write_reg(irs_pkg::REG_WAIT_TICKS, setting);
      repeat (RandItems) send_item(random_item(), 1'b0, '0);
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
